// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the link receiver rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define FLR_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("flr assertion failed");

// next-cycle implication, off during reset
`define FLR_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("flr assertion failed");

`endif

// ===== rtl/core/flr_pkg.sv =====
// shared types and constants for the framed link receiver
// no dependencies
package flr_pkg;

  localparam int FRAME_BYTES_DEF  = 132;
  localparam int PAGE_BYTES_DEF   = 128;
  localparam int ADDRESS_BITS_DEF = 23;
  localparam int QUEUE_DEPTH      = 4;

  localparam int POS_W  = 8;
  localparam int PAGE_W = 16;

  typedef logic [3:0] ev_t;
  typedef logic [1:0] mode_t;

  // control characters
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ENQ = 8'h05;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_DLE = 8'h10;
  localparam logic [7:0] CH_FS  = 8'h1C;

  // result event codes
  localparam ev_t EV_ACK    = 4'd0;
  localparam ev_t EV_UP     = 4'd1;
  localparam ev_t EV_DOWN   = 4'd2;
  localparam ev_t EV_ERASE  = 4'd3;
  localparam ev_t EV_CBYTE  = 4'd4;
  localparam ev_t EV_CEND   = 4'd5;
  localparam ev_t EV_DBYTE  = 4'd6;
  localparam ev_t EV_COMMIT = 4'd7;
  localparam ev_t EV_REJECT = 4'd8;
  localparam ev_t EV_SEND   = 4'd9;

  // link modes
  localparam mode_t MODE_WAIT   = 2'd0;
  localparam mode_t MODE_INTER  = 2'd1;
  localparam mode_t MODE_STREAM = 2'd2;

  // trailer progress
  localparam logic [1:0] TRAIL_IDLE = 2'd0;
  localparam logic [1:0] TRAIL_FS   = 2'd1;
  localparam logic [1:0] TRAIL_FF   = 2'd2;

  // one classified byte: up to two results, payload shared
  typedef struct packed {
    ev_t              ev0;
    ev_t              ev1;
    logic             two;
    logic [7:0]       value;
    logic [POS_W-1:0] index;
    logic             ok;
  } flr_entry_t;

endpackage

// ===== rtl/core/framed_link_receiver.sv =====
// framed link receiver, one received byte per request on the input side
// each result goes through the queue, then the output register; a pair leaves one at a time
// throughput: one byte per cycle while the queue has room; results leave one per cycle,
// set by the output register, while out_ready is high; a 4-entry queue absorbs bursts
// reset: synchronous active-low; link waiting, page one, queue and output empty
`include "assert_macros.svh"

module framed_link_receiver import flr_pkg::*; #(
  parameter int FRAME_BYTES  = FRAME_BYTES_DEF,
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [3:0]              out_event_res,
  output logic [7:0]              out_value,
  output logic [7:0]              out_frame_index,
  output logic [ADDRESS_BITS-1:0] out_flash_address,
  output logic                    out_frame_ok,
  output logic                    out_last
);

  localparam int ENTRY_W = $bits(flr_entry_t);
  localparam int Q_W     = ENTRY_W + ADDRESS_BITS;

  logic                    push;
  flr_entry_t              push_entry;
  logic [ADDRESS_BITS-1:0] push_addr;
  logic                    q_full;
  logic                    q_empty;
  logic                    pop;
  logic [Q_W-1:0]          q_rd;
  flr_entry_t              head_entry;
  logic [ADDRESS_BITS-1:0] head_addr;
  logic                    pair_head;

  flr_front #(
    .FRAME_BYTES  (FRAME_BYTES),
    .PAGE_BYTES   (PAGE_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry),
    .push_addr  (push_addr)
  );

  flr_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data ({push_entry, push_addr}),
    .rd_en   (pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  assign head_entry = q_rd[Q_W-1:ADDRESS_BITS];
  assign head_addr  = q_rd[ADDRESS_BITS-1:0];

  flr_back #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .head_entry        (head_entry),
    .head_addr         (head_addr),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_res     (out_event_res),
    .out_value         (out_value),
    .out_frame_index   (out_frame_index),
    .out_flash_address (out_flash_address),
    .out_frame_ok      (out_frame_ok),
    .out_last          (out_last)
  );

  // events that can open a pair of results
  assign pair_head = (out_event_res == EV_UP) || (out_event_res == EV_CBYTE) ||
                     (out_event_res == EV_ERASE) || (out_event_res == EV_ACK) ||
                     (out_event_res == EV_COMMIT) || (out_event_res == EV_SEND);

  // classifier never writes into a full queue
  `FLR_ASSERT_IMP(a_no_overflow, push, !q_full)
  // an idle byte leaves nothing behind
  `FLR_ASSERT_IMP(a_zero_silent, in_valid && in_ready && in_rx_byte == CH_NUL, !push)
  // only the opening result of a pair may come without last
  `FLR_ASSERT_IMP(a_pair_first, out_valid && !out_last, pair_head)
  // the second half of a pair is never dropped while the first is taken
  `FLR_ASSERT_NXT(a_pair_follows, out_valid && out_ready && !out_last, out_valid)

endmodule

// ===== rtl/core/flr_queue.sv =====
// small fifo between the classifier and the result sequencer
// depends on nothing but its parameters
module flr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/flr_front.sv =====
// byte classifier: link state, frame tracking and page addressing
// depends on flr_pkg
module flr_front import flr_pkg::*; #(
  parameter int FRAME_BYTES  = FRAME_BYTES_DEF,
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_rx_byte,
  input  logic                    q_full,
  output logic                    push,
  output flr_entry_t              push_entry,
  output logic [ADDRESS_BITS-1:0] push_addr
);

  localparam logic [POS_W-1:0]        POS_LAST   = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0]        DATA_FIRST = POS_W'(3);
  localparam logic [POS_W-1:0]        DATA_LAST  = POS_W'(PAGE_BYTES + 1);
  localparam logic [POS_W-1:0]        POS_SEQ    = POS_W'(1);
  localparam logic [ADDRESS_BITS-1:0] PAGE_STEP  = ADDRESS_BITS'(PAGE_BYTES);

  mode_t                   mode_r, mode_nxt;
  logic                    in_frame_r, in_frame_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic                    seq_r, seq_nxt;
  logic [PAGE_W-1:0]       page_r, page_nxt;
  logic [ADDRESS_BITS-1:0] base_r, base_nxt;
  logic [1:0]              trail_r, trail_nxt;

  logic             fire;
  logic             seq_eff;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] data_off;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready && (in_rx_byte != CH_NUL);
  assign seq_eff  = seq_r || (pos_r == POS_SEQ);
  assign pos_inc  = pos_r + POS_W'(1);
  assign data_off = pos_r - DATA_FIRST;

  always_comb begin
    mode_nxt     = mode_r;
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    seq_nxt      = seq_r;
    page_nxt     = page_r;
    base_nxt     = base_r;
    trail_nxt    = trail_r;
    push         = 1'b0;
    push_entry   = '0;
    push_addr    = '0;

    if (fire) begin
      case (mode_r)
        MODE_INTER: begin
          if (in_frame_r) begin
            seq_nxt          = seq_eff;
            push             = 1'b1;
            push_entry.ev0   = EV_CBYTE;
            push_entry.value = in_rx_byte;
            push_entry.index = pos_r;
            if (in_rx_byte == CH_ETX || pos_r >= POS_LAST) begin
              push_entry.two = 1'b1;
              push_entry.ev1 = EV_CEND;
              push_entry.ok  = (in_rx_byte == CH_ETX) && seq_eff;
              in_frame_nxt   = 1'b0;
              pos_nxt        = '0;
            end else begin
              pos_nxt = pos_inc;
            end
          end else if (in_rx_byte == CH_SOH) begin
            in_frame_nxt     = 1'b1;
            seq_nxt          = 1'b0;
            pos_nxt          = POS_W'(1);
            push             = 1'b1;
            push_entry.ev0   = EV_CBYTE;
            push_entry.value = in_rx_byte;
          end else if (in_rx_byte == CH_DLE) begin
            page_nxt       = PAGE_W'(1);
            base_nxt       = '0;
            trail_nxt      = TRAIL_IDLE;
            pos_nxt        = '0;
            mode_nxt       = MODE_STREAM;
            push           = 1'b1;
            push_entry.ev0 = EV_ERASE;
            push_entry.ev1 = EV_ACK;
            push_entry.two = 1'b1;
          end else if (in_rx_byte == CH_EOT) begin
            pos_nxt        = '0;
            mode_nxt       = MODE_WAIT;
            push           = 1'b1;
            push_entry.ev0 = EV_ACK;
            push_entry.ev1 = EV_DOWN;
            push_entry.two = 1'b1;
          end
        end
        MODE_STREAM: begin
          if (in_frame_r) begin
            seq_nxt = seq_eff;
            if (pos_r >= POS_LAST) begin
              push         = 1'b1;
              in_frame_nxt = 1'b0;
              pos_nxt      = '0;
              if (in_rx_byte == CH_ETX && seq_eff) begin
                push_entry.ev0 = EV_COMMIT;
                push_entry.ev1 = EV_ACK;
                push_entry.two = 1'b1;
                push_entry.ok  = 1'b1;
                push_addr      = base_r;
                page_nxt       = page_r + PAGE_W'(1);
                // page number wraps to zero, whose base sits one page below zero
                if (page_r == '1) begin
                  base_nxt = '0 - PAGE_STEP;
                end else begin
                  base_nxt = base_r + PAGE_STEP;
                end
              end else begin
                push_entry.ev0 = EV_REJECT;
              end
            end else begin
              pos_nxt = pos_inc;
              if (pos_r >= DATA_FIRST && pos_r <= DATA_LAST) begin
                push             = 1'b1;
                push_entry.ev0   = EV_DBYTE;
                push_entry.value = in_rx_byte;
                push_entry.index = pos_r;
                push_addr        = base_r + ADDRESS_BITS'(data_off);
              end
            end
          end else if (trail_r == TRAIL_FS) begin
            trail_nxt = (in_rx_byte == CH_FF) ? TRAIL_FF : TRAIL_IDLE;
          end else if (trail_r == TRAIL_FF) begin
            trail_nxt = TRAIL_IDLE;
            if (in_rx_byte == CH_EOT) begin
              mode_nxt       = MODE_INTER;
              page_nxt       = PAGE_W'(1);
              base_nxt       = '0;
              push           = 1'b1;
              push_entry.ev0 = EV_SEND;
              push_entry.ev1 = EV_ACK;
              push_entry.two = 1'b1;
            end
          end else if (in_rx_byte == CH_SOH) begin
            trail_nxt    = TRAIL_IDLE;
            in_frame_nxt = 1'b1;
            seq_nxt      = 1'b0;
            pos_nxt      = POS_W'(1);
          end else if (in_rx_byte == CH_FS) begin
            trail_nxt = TRAIL_FS;
          end else begin
            trail_nxt = TRAIL_IDLE;
          end
        end
        default: begin
          // waiting, and the unused mode code behaves the same
          if (in_rx_byte == CH_ENQ) begin
            mode_nxt       = MODE_INTER;
            in_frame_nxt   = 1'b0;
            pos_nxt        = '0;
            push           = 1'b1;
            push_entry.ev0 = EV_UP;
            push_entry.ev1 = EV_ACK;
            push_entry.two = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_WAIT;
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      seq_r      <= 1'b0;
      page_r     <= PAGE_W'(1);
      base_r     <= '0;
      trail_r    <= TRAIL_IDLE;
    end else begin
      mode_r     <= mode_nxt;
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      seq_r      <= seq_nxt;
      page_r     <= page_nxt;
      base_r     <= base_nxt;
      trail_r    <= trail_nxt;
    end
  end

endmodule

// ===== rtl/core/flr_back.sv =====
// result sequencer: splits queued entries into single results
// depends on flr_pkg
module flr_back import flr_pkg::*; #(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  flr_entry_t              head_entry,
  input  logic [ADDRESS_BITS-1:0] head_addr,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [3:0]              out_event_res,
  output logic [7:0]              out_value,
  output logic [7:0]              out_frame_index,
  output logic [ADDRESS_BITS-1:0] out_flash_address,
  output logic                    out_frame_ok,
  output logic                    out_last
);

  logic                    valid_r, valid_nxt;
  logic                    phase_r, phase_nxt;
  ev_t                     ev_r;
  logic [7:0]              value_r;
  logic [POS_W-1:0]        index_r;
  logic [ADDRESS_BITS-1:0] addr_r;
  logic                    ok_r;
  logic                    last_r;

  logic load;
  logic last_sel;
  ev_t  ev_sel;
  logic has_byte;
  logic has_addr;
  logic has_ok;

  assign load     = !q_empty && (!valid_r || out_ready);
  assign last_sel = phase_r || !head_entry.two;
  assign ev_sel   = phase_r ? head_entry.ev1 : head_entry.ev0;
  assign pop      = load && last_sel;
  assign has_byte = (ev_sel == EV_CBYTE) || (ev_sel == EV_DBYTE);
  assign has_addr = (ev_sel == EV_DBYTE) || (ev_sel == EV_COMMIT);
  assign has_ok   = (ev_sel == EV_CEND) || (ev_sel == EV_COMMIT);

  always_comb begin
    phase_nxt = phase_r;
    valid_nxt = valid_r;
    if (load) begin
      phase_nxt = !last_sel;
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r    <= ev_sel;
      value_r <= has_byte ? head_entry.value : 8'd0;
      index_r <= has_byte ? head_entry.index : '0;
      addr_r  <= has_addr ? head_addr : '0;
      ok_r    <= has_ok && head_entry.ok;
      last_r  <= last_sel;
    end
  end

  assign out_valid         = valid_r;
  assign out_event_res     = ev_r;
  assign out_value         = value_r;
  assign out_frame_index   = index_r;
  assign out_flash_address = addr_r;
  assign out_frame_ok      = ok_r;
  assign out_last          = last_r;

endmodule
